>>> rtl/radial_kernel_weight_defines.svh
// Assertion macros shared by the radial kernel weight RTL.
`ifndef RADIAL_KERNEL_WEIGHT_DEFINES_SVH
`define RADIAL_KERNEL_WEIGHT_DEFINES_SVH
`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define RKW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("radial kernel weight assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define RKW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("radial kernel weight assertion failed");
`else
`define RKW_ASSERT_IMP(lbl, ante, cons)
`define RKW_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/rkw_pkg.sv
// Types and constants of the radial kernel weight block.
package rkw_pkg;

    // Formats of the distance, radius and weight.
    localparam int DIST_WIDTH  = 24;
    localparam int WEIGHT_FRAC = 16;
    localparam int W_WIDTH     = WEIGHT_FRAC + 1;
    localparam int MODE_WIDTH  = 3;

    // Internal fractions are Q.31, with one more bit to hold 1.0.
    localparam int Q_FRAC  = 31;
    localparam int Q_WIDTH = Q_FRAC + 1;
    localparam int M1_WIDTH  = Q_WIDTH + 1;
    localparam int ACC_WIDTH = Q_WIDTH + 2;
    localparam logic [Q_WIDTH-1:0] Q_ONE  = {1'b1, {Q_FRAC{1'b0}}};
    localparam logic [Q_WIDTH-1:0] Q_HALF = {2'b01, {(Q_FRAC-1){1'b0}}};
    localparam logic [W_WIDTH-1:0] ONE_W  = {1'b1, {WEIGHT_FRAC{1'b0}}};
    localparam logic [W_WIDTH-1:0] HALF_W = {2'b01, {(WEIGHT_FRAC-1){1'b0}}};

    // Kernel constants.
    localparam logic [Q_WIDTH-1:0] LN10_Q24    = 32'd38630967;
    localparam int                 LN10_SHIFT  = 26;
    localparam logic [Q_WIDTH-1:0] HALF_PI_Q31 = 32'd3373259426;
    localparam logic [M1_WIDTH-1:0] Z_LIMIT    = M1_WIDTH'(3) << 29;

    // Iteration counts.
    localparam int EXP_TERMS     = 13;
    localparam int COS_TERMS     = 7;
    localparam int EXP_SQUARINGS = 5;
    localparam int SER_STAGES    = 2 * EXP_TERMS;

    // Long division: two quotient bits per stage.
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = (Q_FRAC + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

    // Reciprocal multiplication for the series divisors.
    localparam int RECIP_SHIFT = 39;
    localparam int RECIP_WIDTH = RECIP_SHIFT + 1;

    // Cycles from the accepting edge to the edge that takes the result.
    localparam int LATENCY = 1 + DIV_STAGES + 3 + SER_STAGES + 1 + EXP_SQUARINGS + 2;

    // Kernel selection held in the mode register.
    typedef enum logic [MODE_WIDTH-1:0] {
        KM_GAUSS   = 3'd0,
        KM_LINEAR  = 3'd1,
        KM_CONST   = 3'd2,
        KM_COSINE  = 3'd3,
        KM_QUARTIC = 3'd4,
        KM_STEP    = 3'd5
    } t_mode;

    // Input transaction.
    typedef struct packed {
        logic [DIST_WIDTH-1:0] distance;
        logic [DIST_WIDTH-1:0] radius;
    } t_in;

    // Result transaction.
    typedef struct packed {
        logic [W_WIDTH-1:0] weight;
        logic               radius_error;
    } t_out;

    // Control that travels down the pipeline with each item.
    typedef struct packed {
        t_mode              mode;
        logic               err;
        logic               lt;
        logic               eq;
        logic               gzero;
        logic               full;
        logic               flip;
        logic [W_WIDTH-1:0] pre_w;
    } t_side;

endpackage

>>> rtl/radial_kernel_weight.sv
// Radial kernel weight: 54-stage pipeline from distance and radius to a Q1.16 weight.
// Each accepted start transaction gives one result, strobed on o_done.
// Throughput: one transaction per cycle; o_busy stays low, as every stage advances each cycle.
// The depth is set by the 16 long-division stages and the 26 stages of the series unit.
// Reset (synchronous, active low) clears all valid bits and sets the mode to gaussian.
// The receiver cannot stall: each result is shown for exactly one cycle.
module radial_kernel_weight (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  rkw_pkg::t_in                      i_item,
    output logic                              o_done,
    output rkw_pkg::t_out                     o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rkw_pkg::MODE_WIDTH-1:0]    i_cfg_data
);
    import rkw_pkg::*;
    `include "radial_kernel_weight_defines.svh"

    localparam logic [2*Q_WIDTH-1:0] RND31   = (2*Q_WIDTH)'(1) << (Q_FRAC - 1);
    localparam logic [Q_WIDTH-1:0]   RND_G   = Q_WIDTH'(1) << (Q_FRAC - 1 - WEIGHT_FRAC);
    localparam logic [2*Q_WIDTH-1:0] RND62   = (2*Q_WIDTH)'(1) << (2*Q_FRAC - 1 - WEIGHT_FRAC);

    t_mode r_kernel_mode;

    // Long division pipeline, index 0 is the input register.
    logic [DIST_WIDTH-1:0] r_rem  [DIV_STAGES+1];
    logic [DIST_WIDTH-1:0] r_den  [DIV_STAGES+1];
    logic [Q_FRAC-1:0]     r_q    [DIV_STAGES+1];
    t_side                 r_dside[DIV_STAGES+1];
    logic                  r_dvld [DIV_STAGES+1];

    // Preparation stage and the first multiplier stage.
    logic [Q_WIDTH-1:0]  r_a_x;
    t_side               r_a_side;
    logic                r_a_vld;
    logic [M1_WIDTH-1:0] r_m1;
    t_side               r_m1_side;
    logic                r_m1_vld;

    // Series unit, index 0 is its input register.
    logic [Q_FRAC-1:0]    r_sx   [SER_STAGES+1];
    logic [Q_WIDTH-1:0]   r_st   [SER_STAGES+1];
    logic [ACC_WIDTH-1:0] r_spos [SER_STAGES+1];
    logic [ACC_WIDTH-1:0] r_sneg [SER_STAGES+1];
    t_side                r_sside[SER_STAGES+1];
    logic                 r_svld [SER_STAGES+1];

    // Squaring stages, index 0 holds the clamped series value.
    logic [Q_WIDTH-1:0] r_qe   [EXP_SQUARINGS+1];
    t_side              r_qside[EXP_SQUARINGS+1];
    logic               r_qvld [EXP_SQUARINGS+1];

    // Final product stage.
    logic [Q_WIDTH-1:0]   r_f_e;
    logic [2*Q_WIDTH-1:0] r_f_prod;
    t_side                r_f_side;
    logic                 r_f_vld;

    // The pipeline never stalls, so both channels are always open.
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Mode register, written by a configuration transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_mode <= KM_GAUSS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_kernel_mode <= t_mode'(i_cfg_data);
        end
    end

    // Input stage: compares and choice of the dividend for the selected kernel.
    logic [DIST_WIDTH-1:0] dst, rad, dmin;
    logic [DIST_WIDTH-1:0] n_num;
    t_side                 n_s0_side;
    assign dst = i_item.distance;
    assign rad = i_item.radius;

    always_comb begin
        n_s0_side       = '0;
        n_s0_side.mode  = r_kernel_mode;
        n_s0_side.err   = (rad == '0);
        n_s0_side.lt    = (dst < rad);
        n_s0_side.eq    = (dst == rad);
        n_s0_side.gzero = ({1'b0, dst} >= {rad, 1'b0});
        dmin = n_s0_side.lt ? dst : rad;
        unique case (r_kernel_mode)
            KM_GAUSS:   n_num = n_s0_side.lt ? dst : dst - rad;
            KM_COSINE:  n_num = dmin;
            KM_QUARTIC: n_num = rad - dmin;
            default:    n_num = n_s0_side.lt ? rad - dst : '0;
        endcase
        n_s0_side.full = (n_num >= rad);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld[0] <= 1'b0;
        end else begin
            r_dvld[0] <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]   <= n_num;
        r_den[0]   <= rad;
        r_q[0]     <= '0;
        r_dside[0] <= n_s0_side;
    end

    // Restoring long division, two quotient bits per stage.
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        logic [DIST_WIDTH-1:0] n_rem;
        logic [Q_FRAC-1:0]     n_q;
        logic [DIST_WIDTH:0]   trial;

        always_comb begin
            n_rem = r_rem[g];
            n_q   = r_q[g];
            trial = '0;
            for (int j = 0; j < DIV_PER_STAGE; j++) begin
                if (g * DIV_PER_STAGE + j < Q_FRAC) begin
                    trial = {n_rem, 1'b0};
                    if (trial >= {1'b0, r_den[g]}) begin
                        trial = trial - {1'b0, r_den[g]};
                        n_q   = {n_q[Q_FRAC-2:0], 1'b1};
                    end else begin
                        n_q   = {n_q[Q_FRAC-2:0], 1'b0};
                    end
                    n_rem = trial[DIST_WIDTH-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvld[g+1] <= 1'b0;
            end else begin
                r_dvld[g+1] <= r_dvld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g+1]   <= n_rem;
            r_den[g+1]   <= r_den[g];
            r_q[g+1]     <= n_q;
            r_dside[g+1] <= r_dside[g];
        end
    end

    // Preparation: quotient to kernel argument, and the weights that need no series.
    logic [Q_WIDTH-1:0] n_q31, n_a_x;
    t_side              n_a_side;

    always_comb begin
        n_a_side       = r_dside[DIV_STAGES];
        n_q31          = n_a_side.full ? Q_ONE : {1'b0, r_q[DIV_STAGES]};
        n_a_x          = '0;
        n_a_side.pre_w = '0;
        unique case (n_a_side.mode)
            KM_GAUSS: begin
                n_a_x = (n_a_side.lt ? '0 : Q_ONE) + n_q31;
            end
            KM_COSINE: begin
                if (n_q31 > Q_HALF) begin
                    n_a_x         = Q_ONE - n_q31;
                    n_a_side.flip = 1'b1;
                end else begin
                    n_a_x = n_q31;
                end
            end
            KM_QUARTIC: begin
                n_a_x = n_q31;
            end
            KM_LINEAR: begin
                n_a_side.pre_w = n_a_side.lt ? n_q31[Q_FRAC-WEIGHT_FRAC +: W_WIDTH] : '0;
            end
            KM_CONST: begin
                n_a_side.pre_w = n_a_side.lt ? ONE_W : '0;
            end
            KM_STEP: begin
                n_a_side.pre_w = n_a_side.lt ? ONE_W : (n_a_side.eq ? HALF_W : '0);
            end
            default: begin
                n_a_side.pre_w = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= r_dvld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_x    <= n_a_x;
        r_a_side <= n_a_side;
    end

    // First multiply: u squared, the cosine angle, or the rounded quartic square.
    logic [Q_WIDTH-1:0]   m1_op;
    logic [2*Q_WIDTH-1:0] n_m1_full;

    always_comb begin
        m1_op     = (r_a_side.mode == KM_COSINE) ? HALF_PI_Q31 : r_a_x;
        n_m1_full = r_a_x * m1_op;
        if (r_a_side.mode == KM_QUARTIC) begin
            n_m1_full = n_m1_full + RND31;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else begin
            r_m1_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1      <= n_m1_full[2*Q_WIDTH-1:Q_FRAC];
        r_m1_side <= r_a_side;
    end

    // Second multiply: the exponent argument or the squared angle, and series set-up.
    logic [M1_WIDTH-1:0]   m2_op;
    logic [2*M1_WIDTH-1:0] m2_prod;
    logic [M1_WIDTH-1:0]   m2_z;
    logic [Q_FRAC-1:0]     n_s0_x;
    logic [ACC_WIDTH-1:0]  n_s0_pos;
    t_side                 n_m2_side;

    always_comb begin
        n_m2_side = r_m1_side;
        m2_op     = (r_m1_side.mode == KM_GAUSS) ? M1_WIDTH'(LN10_Q24) : r_m1;
        m2_prod   = r_m1 * m2_op;
        m2_z      = m2_prod[LN10_SHIFT +: M1_WIDTH];
        n_s0_pos  = ACC_WIDTH'(Q_ONE);
        unique case (r_m1_side.mode)
            KM_GAUSS: begin
                n_s0_x          = m2_z[Q_FRAC-1:0];
                n_m2_side.gzero = r_m1_side.gzero || (m2_z >= Z_LIMIT);
            end
            KM_COSINE: begin
                n_s0_x = m2_prod[Q_FRAC +: Q_FRAC];
            end
            KM_QUARTIC: begin
                n_s0_x   = '0;
                n_s0_pos = ACC_WIDTH'(r_m1);
            end
            default: begin
                n_s0_x = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svld[0] <= 1'b0;
        end else begin
            r_svld[0] <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx[0]    <= n_s0_x;
        r_st[0]    <= Q_ONE;
        r_spos[0]  <= n_s0_pos;
        r_sneg[0]  <= '0;
        r_sside[0] <= n_m2_side;
    end

    // Series unit: each term is a multiply stage followed by a reciprocal-divide stage.
    for (genvar k = 1; k <= SER_STAGES; k++) begin : g_ser
        localparam int N = (k + 1) / 2;
        logic [Q_WIDTH-1:0]   n_t;
        logic [ACC_WIDTH-1:0] n_pos, n_neg;

        if (k % 2 == 1) begin : g_mul
            logic [Q_WIDTH+Q_FRAC-1:0] prod;

            // Term times the series argument.
            always_comb begin
                prod  = r_st[k-1] * r_sx[k-1];
                n_t   = prod[Q_FRAC +: Q_WIDTH];
                n_pos = r_spos[k-1];
                n_neg = r_sneg[k-1];
            end
        end else begin : g_dvd
            localparam int G_DIV = N;
            localparam int C_DIV = (N <= COS_TERMS) ? (2 * N - 1) * (2 * N) : 1;
            localparam logic [RECIP_WIDTH-1:0] G_RECIP =
                RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + G_DIV - 1) / G_DIV);
            localparam logic [RECIP_WIDTH-1:0] C_RECIP =
                RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + C_DIV - 1) / C_DIV);
            logic [RECIP_WIDTH-1:0]        recip;
            logic [Q_FRAC+RECIP_WIDTH-1:0] prod;
            logic                          kill;

            // Division by the term's factor through its rounded-up reciprocal, then the alternating sums.
            always_comb begin
                recip = (r_sside[k-1].mode == KM_COSINE) ? C_RECIP : G_RECIP;
                prod  = r_st[k-1][Q_FRAC-1:0] * recip;
                kill  = (r_sside[k-1].mode == KM_QUARTIC) ||
                        ((r_sside[k-1].mode == KM_COSINE) && (N > COS_TERMS));
                n_t   = kill ? '0 : Q_WIDTH'(prod >> RECIP_SHIFT);
                n_pos = r_spos[k-1];
                n_neg = r_sneg[k-1];
                if (N % 2 == 1) begin
                    n_neg = r_sneg[k-1] + ACC_WIDTH'(n_t);
                end else begin
                    n_pos = r_spos[k-1] + ACC_WIDTH'(n_t);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_svld[k] <= 1'b0;
            end else begin
                r_svld[k] <= r_svld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sx[k]    <= r_sx[k-1];
            r_st[k]    <= n_t;
            r_spos[k]  <= n_pos;
            r_sneg[k]  <= n_neg;
            r_sside[k] <= r_sside[k-1];
        end
    end

    // Series result: difference of the sums, floored at zero and clamped to one.
    logic [ACC_WIDTH-1:0] e_diff;
    logic [Q_WIDTH-1:0]   n_e;

    always_comb begin
        e_diff = (r_spos[SER_STAGES] > r_sneg[SER_STAGES]) ?
                 r_spos[SER_STAGES] - r_sneg[SER_STAGES] : '0;
        n_e    = (e_diff > ACC_WIDTH'(Q_ONE)) ? Q_ONE : e_diff[Q_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qvld[0] <= 1'b0;
        end else begin
            r_qvld[0] <= r_svld[SER_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_qe[0]    <= n_e;
        r_qside[0] <= r_sside[SER_STAGES];
    end

    // Repeated rounded squaring that turns exp(-z) into the gaussian value.
    for (genvar j = 0; j < EXP_SQUARINGS; j++) begin : g_sq
        logic [2*Q_WIDTH-1:0] sq;
        logic [Q_WIDTH-1:0]   n_qe;

        always_comb begin
            sq   = r_qe[j] * r_qe[j] + RND31;
            n_qe = (r_qside[j].mode == KM_GAUSS) ? sq[Q_FRAC +: Q_WIDTH] : r_qe[j];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qvld[j+1] <= 1'b0;
            end else begin
                r_qvld[j+1] <= r_qvld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_qe[j+1]    <= n_qe;
            r_qside[j+1] <= r_qside[j];
        end
    end

    // Final square for the cosine and quartic kernels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_qvld[EXP_SQUARINGS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_e    <= r_qe[EXP_SQUARINGS];
        r_f_prod <= r_qe[EXP_SQUARINGS] * r_qe[EXP_SQUARINGS];
        r_f_side <= r_qside[EXP_SQUARINGS];
    end

    // Output stage: rounding to the weight format and selection by kernel.
    logic [Q_WIDTH-1:0]   g_sum;
    logic [2*Q_WIDTH-1:0] c_sum;
    logic [W_WIDTH-1:0]   gw, cw;
    t_out                 n_result;

    always_comb begin
        g_sum = r_f_e + RND_G;
        c_sum = r_f_prod + RND62;
        gw    = g_sum[Q_FRAC-WEIGHT_FRAC +: W_WIDTH];
        cw    = c_sum[2*Q_FRAC-WEIGHT_FRAC +: W_WIDTH];
        n_result.radius_error = r_f_side.err;
        unique case (r_f_side.mode)
            KM_GAUSS:   n_result.weight = r_f_side.gzero ? '0 : gw;
            KM_COSINE:  n_result.weight = r_f_side.flip ? ONE_W - cw : cw;
            KM_QUARTIC: n_result.weight = cw;
            KM_LINEAR,
            KM_CONST,
            KM_STEP:    n_result.weight = r_f_side.pre_w;
            default:    n_result.weight = '0;
        endcase
        if (r_f_side.err) begin
            n_result.weight = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= n_result;
    end

    // A result transaction appears only for a start transaction the pipeline depth earlier.
    `RKW_ASSERT_IMP(a_done_latency, o_done, $past(i_start, LATENCY))
    // A zero radius always gives a zero weight.
    `RKW_ASSERT_IMP(a_err_zero, o_done && o_result.radius_error, o_result.weight == '0)
    // No kernel produces a weight above one.
    `RKW_ASSERT_IMP(a_weight_max, o_done, o_result.weight <= ONE_W)
    // A configuration transaction lands in the mode register.
    `RKW_ASSERT_NXT(a_cfg_write, i_cfg_valid && o_cfg_ready, r_kernel_mode == $past(i_cfg_data))

endmodule
